>>> hdl/pafd_pkg.sv
// Package for the package attribute field decoder.
// Holds field kind codes, field widths and stream bus widths.
// No dependencies; imported by package_attribute_field_decoder.
package pafd_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int LEN_W    = 33;
  localparam int POS_W    = 3;

  // Slave side: tdata carries data_byte, tuser carries command.
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = KIND_W;

  // Master side: tdata carries field_value and string_length, padded to bytes.
  localparam int M_TDATA_RAW = VALUE_W + LEN_W;
  localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;
  localparam int M_TUSER_W   = KIND_W + 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_INT32   = 3'd0;
  localparam kind_t KIND_BOOL    = 3'd1;
  localparam kind_t KIND_ENUM    = 3'd2;
  localparam kind_t KIND_FLOAT   = 3'd3;
  localparam kind_t KIND_COMPACT = 3'd4;
  localparam kind_t KIND_STRING  = 3'd5;

  // Byte positions inside a compact field.
  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_ONE   = 3'd1;
  localparam logic [POS_W-1:0] POS_TWO   = 3'd2;
  localparam logic [POS_W-1:0] POS_THREE = 3'd3;
  localparam logic [POS_W-1:0] POS_LAST  = 3'd4;

endpackage

>>> hdl/package_attribute_field_decoder.sv
// Top level of the package attribute field decoder: byte stream in, decoded fields out.
// Depends on pafd_pkg for kind codes and bus widths.
//
//  channel   dir  item                       tdata                       tuser
//  s_axis    in   one byte of the stream     [7:0] data_byte             [2:0] command
//  m_axis    out  one decoded field          [31:0] field_value,         [2:0] field_kind,
//                                            [64:32] string_length,      [3] invalid_bool,
//                                            [71:65] zero                [4] wide_chars
//
// One input item is taken per clock. A result is registered from the item that ends its
// field and shown in the cycle after it, through a single output register that frees up
// in the cycle it is read, so items flow with no gaps while the consumer keeps up.
// A stalled output register holds off the input until it is read.
// rst (synchronous, active high) returns the decoder to a field start and empties
// the output register.
module package_attribute_field_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pafd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
  input  logic [pafd_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [2:0] command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pafd_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [31:0] field_value,
                                                        // [64:32] string_length, rest zero
  output logic [pafd_pkg::M_TUSER_W-1:0] m_axis_tuser   // [2:0] field_kind,
                                                        // [3] invalid_bool, [4] wide_chars
);
  import pafd_pkg::*;

  // Field decode state.
  logic [POS_W-1:0]   pos, pos_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               neg, neg_next;
  kind_t              kind, kind_next;

  // Output register.
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  kind_t              out_kind;
  logic               out_bad;
  logic               out_wide;
  logic [LEN_W-1:0]   out_len;

  logic                in_fire;
  logic                start;
  logic                drop;
  logic                done;
  logic [BYTE_W-1:0]   din;
  kind_t               kind_cur;
  logic                fixed_kind;
  logic [VALUE_W-1:0]  acc_base;
  logic [VALUE_W-1:0]  acc_full;
  logic [VALUE_W-1:0]  acc_neg;
  logic [VALUE_W-1:0]  acc_inc;
  logic                neg_eff;
  logic [VALUE_W-1:0]  cmp_value;
  logic [VALUE_W-1:0]  cmp_minus;
  logic [VALUE_W-1:0]  res_value;
  logic                res_bad;
  logic                res_wide;
  logic [LEN_W-1:0]    res_len;

  // The output register accepts a new result whenever it is empty or being read.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign din      = s_axis_tdata[BYTE_W-1:0];
  assign start    = (pos == POS_FIRST);
  assign kind_cur = start ? kind_t'(s_axis_tuser) : kind;
  // An unknown command on a field's first byte discards that byte.
  assign drop     = start && (kind_cur > KIND_STRING);
  assign fixed_kind = (kind_cur <= KIND_FLOAT);
  assign acc_base = start ? '0 : acc;

  // Gather the bits of this byte into the accumulator and decide whether the
  // field ends here.
  always_comb begin
    acc_full = acc_base;
    done     = 1'b0;
    neg_eff  = neg;
    if (fixed_kind) begin
      // Four little-endian bytes.
      case (pos[1:0])
        2'd0:    acc_full = acc_base | {24'b0, din};
        2'd1:    acc_full = acc_base | {16'b0, din, 8'b0};
        2'd2:    acc_full = acc_base | {8'b0, din, 16'b0};
        default: acc_full = acc_base | {din, 24'b0};
      endcase
      done = (pos >= POS_THREE);
    end else begin
      case (pos)
        POS_FIRST: begin
          neg_eff  = din[7];
          acc_full = {26'b0, din[5:0]};
          done     = !din[6];
        end
        POS_ONE: begin
          acc_full = acc_base | {19'b0, din[6:0], 6'b0};
          done     = !din[7];
        end
        POS_TWO: begin
          acc_full = acc_base | {12'b0, din[6:0], 13'b0};
          done     = !din[7];
        end
        POS_THREE: begin
          acc_full = acc_base | {5'b0, din[6:0], 20'b0};
          done     = !din[7];
        end
        default: begin
          // The fifth byte adds the top five bits and always ends the field.
          acc_full = acc_base | {din[4:0], 27'b0};
          done     = 1'b1;
        end
      endcase
    end
  end

  // One shared negation gives both the signed compact value and its negative,
  // which the string length needs when the value is negative.
  assign acc_neg   = '0 - acc_full;
  assign acc_inc   = acc_full + VALUE_W'(1);
  assign cmp_value = neg_eff ? acc_neg : acc_full;
  assign cmp_minus = neg_eff ? acc_full : acc_neg;

  always_comb begin
    res_value = acc_full;
    res_bad   = 1'b0;
    res_wide  = 1'b0;
    res_len   = '0;
    if (fixed_kind) begin
      if (kind_cur == KIND_BOOL) begin
        if (acc_full > VALUE_W'(1)) begin
          res_value = '0;
          res_bad   = 1'b1;
        end
      end else if (kind_cur == KIND_ENUM) begin
        if (acc_full[VALUE_W-1]) begin
          res_value = acc_inc;
        end
      end
    end else begin
      res_value = cmp_value;
      if (kind_cur == KIND_STRING) begin
        // A negative value marks a UTF-16 body whose length is twice its size;
        // zero gives an empty string with the UTF-8 flag.
        if (cmp_value[VALUE_W-1]) begin
          res_wide = 1'b1;
          res_len  = {cmp_minus, 1'b0};
        end else begin
          res_len  = {1'b0, cmp_value};
        end
      end
    end
  end

  always_comb begin
    pos_next  = pos;
    acc_next  = acc;
    neg_next  = neg;
    kind_next = kind;
    if (in_fire && !drop) begin
      kind_next = kind_cur;
      if (done) begin
        pos_next = POS_FIRST;
        acc_next = '0;
        neg_next = 1'b0;
      end else begin
        pos_next = pos + POS_W'(1);
        acc_next = acc_full;
        neg_next = neg_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_FIRST;
      acc  <= '0;
      neg  <= 1'b0;
      kind <= KIND_INT32;
    end else begin
      pos  <= pos_next;
      acc  <= acc_next;
      neg  <= neg_next;
      kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && !drop && done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !drop && done) begin
      out_value <= res_value;
      out_kind  <= kind_cur;
      out_bad   <= res_bad;
      out_wide  <= res_wide;
      out_len   <= res_len;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_TDATA_W - M_TDATA_RAW)'(0), out_len, out_value};
  assign m_axis_tuser  = {out_wide, out_bad, out_kind};

  // The field position never runs past the fifth byte of a compact field.
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_LAST)
    else $error("field byte position out of range");

  // Only a bool field can report an invalid value, and then its value is zero.
  a_bad_bool: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_kind == KIND_BOOL && out_value == '0)
    else $error("invalid flag on a field that is not a bad bool");

  // The UTF-16 flag only comes with a non-empty string header.
  a_wide_string: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_wide |-> out_kind == KIND_STRING && out_len != '0)
    else $error("wide flag without a non-empty string header");

  // A result always follows an accepted byte that ends a field.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("result appeared without an accepted byte");

endmodule
